FILE: src/rcdd_pkg.sv
// Shared types, codes and helper functions for the clock-calendar display driver.
package rcdd_pkg;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_BUTTON = 2'd1;
	localparam logic [1:0] OP_RX     = 2'd2;

	typedef enum logic [1:0] {
		MODE_TIME = 2'd0,
		MODE_DATE = 2'd1,
		MODE_OFF  = 2'd3
	} disp_mode_t;

	typedef struct packed {
		disp_mode_t  mode;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [15:0] c;
	} disp_entry_t;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [3:0] ADDR_SHUTDOWN  = 4'd12;
	localparam logic [3:0] ADDR_DIGIT0    = 4'd1;
	localparam logic [3:0] ADDR_TOP_DIGIT = 4'd8;
	localparam logic [3:0] LAST_INDEX     = 4'd8;
	localparam logic [2:0] YEAR_DIGITS    = 3'd4;

	localparam logic [7:0] SHUTDOWN_ON  = 8'd1;
	localparam logic [7:0] SHUTDOWN_OFF = 8'd0;
	localparam logic [7:0] DASH_CODE    = 8'd10;
	localparam logic [7:0] DP_BIT       = 8'h80;
	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_DASH   = 8'h2D;
	localparam logic [3:0] MSG_LAST     = 4'd9;

	localparam logic [7:0]  MONTHS      = 8'd12;
	localparam logic [13:0] INV25_14    = 14'h1C29;
	localparam logic [13:0] LIM25_14    = 14'd655;
	localparam logic [11:0] INV25_12    = 12'hC29;
	localparam logic [11:0] LIM25_12    = 12'd163;

	function automatic logic is_leap(input logic [15:0] y);
		logic [13:0] p4;
		logic [11:0] p16;
		p4  = 14'(y[15:2] * INV25_14);
		p16 = 12'(y[15:4] * INV25_12);
		return ((y[1:0] == 2'b00) && !(p4 <= LIM25_14)) ||
			((y[3:0] == 4'b0000) && (p16 <= LIM25_12));
	endfunction

	function automatic logic mod60_zero(input logic [7:0] v);
		return (v == 8'd0) || (v == 8'd60) || (v == 8'd120) || (v == 8'd180) ||
			(v == 8'd240);
	endfunction

	function automatic logic mod24_zero(input logic [7:0] v);
		return (v == 8'd0) || (v == 8'd24) || (v == 8'd48) || (v == 8'd72) ||
			(v == 8'd96) || (v == 8'd120) || (v == 8'd144) || (v == 8'd168) ||
			(v == 8'd192) || (v == 8'd216) || (v == 8'd240);
	endfunction

	function automatic logic [4:0] month_days(input logic [7:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			8'd4, 8'd6, 8'd9, 8'd11: d = 5'd30;
			8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: d = 5'd31;
			default: d = leap ? 5'd29 : 5'd28;
		endcase
		return d;
	endfunction

	function automatic logic [7:0] ascii2(input logic [7:0] hi, input logic [7:0] lo);
		return 8'(lo + hi * 8'd10 - ASCII_ZERO * 8'd11);
	endfunction

	function automatic logic [15:0] ascii4(input logic [7:0] d3, input logic [7:0] d2,
		input logic [7:0] d1, input logic [7:0] d0);
		return 16'(16'(d0) + 16'(d1) * 16'd10 + 16'(d2) * 16'd100 + 16'(d3) * 16'd1000 -
			16'(ASCII_ZERO) * 16'd1111);
	endfunction

endpackage

FILE: src/rcdd_front.sv
// Front end: takes requests, keeps clock, calendar, buttons and set message, queues display runs.
module rcdd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           op,
	input  logic                 sw3_pressed,
	input  logic                 sw2_pressed,
	input  logic [7:0]           rx_byte,
	input  logic                 q_full,
	output logic                 push,
	output rcdd_pkg::disp_entry_t entry
);

	logic [7:0]  seconds_q, minutes_q, hours_q, day_q, month_q;
	logic [15:0] year_q;
	rcdd_pkg::disp_mode_t mode_q;
	logic        flag1_q, flag2_q;
	logic [3:0]  msg_count_q;
	logic [7:0]  msg_buf_q [0:8];
	logic        leap_q, year_pend_q;

	logic [7:0]  seconds_d, minutes_d, hours_d, day_d, month_d;
	logic [15:0] year_d;
	rcdd_pkg::disp_mode_t mode_d, m_t;
	logic        flag1_d, flag2_d;
	logic [3:0]  msg_count_d;
	logic        buf_we, year_chg, accept;

	logic        c_sec, c_min, c_hr, c_day, c_mo;
	logic [7:0]  m_inc, h_inc, d_inc, mo_inc;
	logic [7:0]  sec_t, min_t, hr_t, day_t, mon_t;
	logic [15:0] yr_t;

	assign in_stall = q_full || year_pend_q;
	assign accept   = in_valid && !in_stall;

	assign m_inc  = minutes_q + 8'd1;
	assign h_inc  = hours_q + 8'd1;
	assign d_inc  = day_q + 8'd1;
	assign mo_inc = month_q + 8'd1;

	assign c_sec = rcdd_pkg::mod60_zero(seconds_q);
	assign c_min = c_sec && rcdd_pkg::mod60_zero(m_inc);
	assign c_hr  = c_min && rcdd_pkg::mod24_zero(h_inc);
	assign c_day = c_hr && (d_inc > {3'b000, rcdd_pkg::month_days(month_q, leap_q)});
	assign c_mo  = c_day && (mo_inc > rcdd_pkg::MONTHS);

	assign sec_t = c_sec ? 8'd0 : seconds_q;
	assign min_t = c_min ? 8'd0 : (c_sec ? m_inc : minutes_q);
	assign hr_t  = c_hr ? 8'd0 : (c_min ? h_inc : hours_q);
	assign day_t = c_day ? 8'd1 : (c_hr ? d_inc : day_q);
	assign mon_t = c_mo ? 8'd1 : (c_day ? mo_inc : month_q);
	assign yr_t  = c_mo ? year_q + 16'd1 : year_q;

	always_comb begin
		seconds_d   = seconds_q;
		minutes_d   = minutes_q;
		hours_d     = hours_q;
		day_d       = day_q;
		month_d     = month_q;
		year_d      = year_q;
		mode_d      = mode_q;
		flag1_d     = flag1_q;
		flag2_d     = flag2_q;
		msg_count_d = msg_count_q;
		buf_we      = 1'b0;
		year_chg    = 1'b0;
		push        = 1'b0;
		m_t         = mode_q;
		entry.mode  = mode_q;
		entry.a     = hr_t;
		entry.b     = min_t;
		entry.c     = {8'd0, sec_t};
		if (accept) begin
			case (op)
				rcdd_pkg::OP_TICK: begin
					seconds_d = sec_t + 8'd1;
					minutes_d = min_t;
					hours_d   = hr_t;
					day_d     = day_t;
					month_d   = mon_t;
					year_d    = yr_t;
					year_chg  = c_mo;
					push      = 1'b1;
					if (mode_q == rcdd_pkg::MODE_DATE) begin
						entry.a = day_t;
						entry.b = mon_t;
						entry.c = yr_t;
					end
				end
				rcdd_pkg::OP_BUTTON: begin
					flag1_d = flag1_q ^ sw3_pressed;
					flag2_d = flag2_q ^ sw2_pressed;
					if (sw3_pressed && (mode_q != rcdd_pkg::MODE_OFF)) begin
						m_t = flag1_d ? rcdd_pkg::MODE_TIME : rcdd_pkg::MODE_DATE;
					end
					if (sw2_pressed) begin
						m_t = !flag2_d ? rcdd_pkg::MODE_OFF :
							(flag1_d ? rcdd_pkg::MODE_TIME : rcdd_pkg::MODE_DATE);
					end
					mode_d = m_t;
				end
				rcdd_pkg::OP_RX: begin
					if (msg_count_q == rcdd_pkg::MSG_LAST) begin
						msg_count_d = 4'd0;
						if (msg_buf_q[2] == rcdd_pkg::ASCII_DASH) begin
							hours_d   = rcdd_pkg::ascii2(msg_buf_q[0], msg_buf_q[1]);
							minutes_d = rcdd_pkg::ascii2(msg_buf_q[4], msg_buf_q[5]);
							seconds_d = rcdd_pkg::ascii2(msg_buf_q[8], rx_byte);
						end else begin
							day_d    = rcdd_pkg::ascii2(msg_buf_q[0], msg_buf_q[1]);
							month_d  = rcdd_pkg::ascii2(msg_buf_q[3], msg_buf_q[4]);
							year_d   = rcdd_pkg::ascii4(msg_buf_q[6], msg_buf_q[7],
								msg_buf_q[8], rx_byte);
							year_chg = 1'b1;
						end
					end else begin
						buf_we      = 1'b1;
						msg_count_d = msg_count_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seconds_q   <= 8'd1;
			minutes_q   <= 8'd0;
			hours_q     <= 8'd0;
			day_q       <= 8'd1;
			month_q     <= 8'd1;
			year_q      <= 16'd1971;
			mode_q      <= rcdd_pkg::MODE_TIME;
			flag1_q     <= 1'b1;
			flag2_q     <= 1'b1;
			msg_count_q <= 4'd0;
			leap_q      <= 1'b0;
			year_pend_q <= 1'b0;
		end else begin
			seconds_q   <= seconds_d;
			minutes_q   <= minutes_d;
			hours_q     <= hours_d;
			day_q       <= day_d;
			month_q     <= month_d;
			year_q      <= year_d;
			mode_q      <= mode_d;
			flag1_q     <= flag1_d;
			flag2_q     <= flag2_d;
			msg_count_q <= msg_count_d;
			leap_q      <= rcdd_pkg::is_leap(year_q);
			year_pend_q <= year_chg;
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			msg_buf_q[msg_count_q] <= rx_byte;
		end
	end

endmodule

FILE: src/rcdd_queue.sv
// Short queue of display runs between the front end and the write sequencer.
module rcdd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rcdd_pkg::disp_entry_t wr_entry,
	input  logic                  pop,
	output logic                  valid,
	output rcdd_pkg::disp_entry_t head,
	output logic                  full
);

	localparam int PTR_W = $clog2(rcdd_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(rcdd_pkg::QUEUE_DEPTH + 1);

	rcdd_pkg::disp_entry_t entries_q [0:rcdd_pkg::QUEUE_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(rcdd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign valid = (count_q != '0);
	assign full  = (count_q == CNT_W'(rcdd_pkg::QUEUE_DEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

FILE: src/rcdd_back.sv
// Write sequencer: turns a queued display run into display register writes.
module rcdd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  rcdd_pkg::disp_entry_t q_head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [3:0]            reg_address,
	output logic [7:0]            reg_data,
	output logic                  last
);

	logic                  busy_q;
	logic [3:0]            idx_q;
	rcdd_pkg::disp_entry_t cur_q;
	logic [15:0]           yq_q;
	logic [2:0]            ystep_q;
	logic [3:0]            ydig_q [0:3];
	logic                  out_valid_q, last_q;
	logic [3:0]            addr_q;
	logic [7:0]            data_q;

	logic        adv, is_last, load;
	logic [7:0]  sel_v;
	logic [15:0] p10;
	logic [4:0]  hi;
	logic [3:0]  lo;
	logic [31:0] py;
	logic [15:0] qn;
	logic [3:0]  ydig;
	logic [3:0]  addr_w;
	logic [7:0]  data_w;

	assign adv     = busy_q && (!out_valid_q || !out_stall);
	assign is_last = (cur_q.mode == rcdd_pkg::MODE_OFF) || (idx_q == rcdd_pkg::LAST_INDEX);
	assign load    = q_valid && (!busy_q || (adv && is_last));
	assign pop     = load;

	always_comb begin
		case (idx_q)
			4'd1, 4'd2:       sel_v = cur_q.a;
			4'd3, 4'd4, 4'd5: sel_v = cur_q.b;
			default:          sel_v = cur_q.c[7:0];
		endcase
	end

	assign p10 = 16'(sel_v) * 16'd205;
	assign hi  = p10[15:11];
	assign lo  = 4'(sel_v[3:0] - {hi[0], 3'b000} - {hi[2:0], 1'b0});

	assign py   = 32'(yq_q) * 32'd52429;
	assign qn   = 16'(py[31:19]);
	assign ydig = 4'(yq_q[3:0] - {qn[0], 3'b000} - {qn[2:0], 1'b0});

	always_comb begin
		addr_w = 4'(rcdd_pkg::ADDR_DIGIT0 + (rcdd_pkg::LAST_INDEX - idx_q));
		data_w = 8'(lo);
		case (cur_q.mode)
			rcdd_pkg::MODE_TIME: begin
				case (idx_q)
					4'd0: begin
						addr_w = rcdd_pkg::ADDR_SHUTDOWN;
						data_w = rcdd_pkg::SHUTDOWN_ON;
					end
					4'd3, 4'd6:       data_w = rcdd_pkg::DASH_CODE;
					4'd1, 4'd4, 4'd7: data_w = 8'(hi);
					default:          data_w = 8'(lo);
				endcase
			end
			rcdd_pkg::MODE_DATE: begin
				case (idx_q)
					4'd0: begin
						addr_w = rcdd_pkg::ADDR_SHUTDOWN;
						data_w = rcdd_pkg::SHUTDOWN_ON;
					end
					4'd1, 4'd3: data_w = 8'(hi);
					4'd2, 4'd4: data_w = rcdd_pkg::DP_BIT | 8'(lo);
					default:    data_w = 8'(ydig_q[2'(rcdd_pkg::LAST_INDEX - idx_q)]);
				endcase
			end
			default: begin
				addr_w = rcdd_pkg::ADDR_SHUTDOWN;
				data_w = rcdd_pkg::SHUTDOWN_OFF;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= 4'd0;
			ystep_q     <= rcdd_pkg::YEAR_DIGITS;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= 4'd0;
			end else if (adv && is_last) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				idx_q <= idx_q + 4'd1;
			end
			if (load) begin
				ystep_q <= 3'd0;
			end else if (ystep_q != rcdd_pkg::YEAR_DIGITS) begin
				ystep_q <= ystep_q + 3'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_head;
			yq_q  <= q_head.c;
		end else if (ystep_q != rcdd_pkg::YEAR_DIGITS) begin
			yq_q                  <= qn;
			ydig_q[ystep_q[1:0]] <= ydig;
		end
		if (adv) begin
			addr_q <= addr_w;
			data_q <= data_w;
			last_q <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign reg_address = addr_q;
	assign reg_data    = data_q;
	assign last        = last_q;

endmodule

FILE: src/rtc_calendar_display_driver_top.sv
// Top level of the clock-calendar display driver.
//
//   channel  side    handshake            payload
//   in       input   in_valid / in_stall  op, sw3_pressed, sw2_pressed, rx_byte
//   out      output  out_valid/out_stall  reg_address, reg_data, last
//
// The front end takes one request per cycle unless the queue is full or a year change is pending.
// A year change comes from a tick that rolls over the year or from a date set message.
// A tick's run passes the run queue and the current-run register before its first write is registered.
// A time or date tick gives nine writes, an off tick one write.
// The two-entry run queue sets how far the front end runs ahead of the write sequencer.
// Reset: 00:00:01 on 01.01.1971, time display, both button flags set, empty set message.
// out_stall holds the output register; the front end keeps accepting until the queue fills.
module rtc_calendar_display_driver_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic       sw3_pressed,
	input  logic       sw2_pressed,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] reg_address,
	output logic [7:0] reg_data,
	output logic       last
);

	logic                  push, pop, q_valid, q_full;
	rcdd_pkg::disp_entry_t wr_entry, q_head;

	rcdd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.sw3_pressed (sw3_pressed),
		.sw2_pressed (sw2_pressed),
		.rx_byte     (rx_byte),
		.q_full      (q_full),
		.push        (push),
		.entry       (wr_entry)
	);

	rcdd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_head),
		.full     (q_full)
	);

	rcdd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.reg_address (reg_address),
		.reg_data    (reg_data),
		.last        (last)
	);

endmodule

FILE: src/rcdd_checker.sv
// Port-level checks on the display write stream, bound to the top level.
module rcdd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] reg_address,
	input logic [7:0] reg_data,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reg_address) &&
			$stable(reg_data) && $stable(last))
		else $error("output request changed while stalled");

	a_off_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reg_address == rcdd_pkg::ADDR_SHUTDOWN) &&
			(reg_data == rcdd_pkg::SHUTDOWN_OFF) |-> last)
		else $error("shutdown write not marked last");

	a_last_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> (reg_address == rcdd_pkg::ADDR_DIGIT0) ||
			((reg_address == rcdd_pkg::ADDR_SHUTDOWN) &&
			(reg_data == rcdd_pkg::SHUTDOWN_OFF)))
		else $error("run ended on a wrong register");

	a_wake_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && (reg_address == rcdd_pkg::ADDR_SHUTDOWN) &&
			(reg_data == rcdd_pkg::SHUTDOWN_ON)
			|=> out_valid && (reg_address == rcdd_pkg::ADDR_TOP_DIGIT))
		else $error("wake write not followed by top digit");

endmodule

bind rtc_calendar_display_driver_top rcdd_checker u_rcdd_checker (.*);
